[sv/tabq_pkg.sv]
package tabq_pkg;

    localparam int FIELD_BITS   = 32;
    localparam int COEF_BITS    = 32;
    localparam int FIELD_LANES  = 3;
    localparam int OP_BITS      = 2;
    localparam int CFG_IDX_BITS = 3;

    // Operation codes; the fourth code is ignored by the datapath.
    typedef enum logic [OP_BITS-1:0] {
        OP_FILTER  = 2'd0,
        OP_PRESEED = 2'd1,
        OP_CLEAR   = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_reg_idx;

    typedef logic signed [FIELD_BITS-1:0] t_field;
    typedef logic signed [COEF_BITS-1:0]  t_coef;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_coefs;

    // Pipeline control shared by all lanes.
    typedef struct packed {
        logic adv;
        logic take;
        t_op  in_op;
        logic s2_vld;
        t_op  s2_op;
    } t_lane_ctl;

endpackage

[sv/tabq_req_if.sv]
interface tabq_req_if;
    logic                              valid;
    logic                              ready;
    logic [tabq_pkg::OP_BITS-1:0]      operation;
    logic signed [tabq_pkg::FIELD_BITS-1:0] sample_x;
    logic signed [tabq_pkg::FIELD_BITS-1:0] sample_y;
    logic signed [tabq_pkg::FIELD_BITS-1:0] sample_z;

    modport source (
        output valid, operation, sample_x, sample_y, sample_z,
        input  ready
    );
    modport sink (
        input  valid, operation, sample_x, sample_y, sample_z,
        output ready
    );
endinterface

[sv/tabq_rsp_if.sv]
interface tabq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [tabq_pkg::FIELD_BITS-1:0] filtered_x;
    logic signed [tabq_pkg::FIELD_BITS-1:0] filtered_y;
    logic signed [tabq_pkg::FIELD_BITS-1:0] filtered_z;
    logic                              saturated;

    modport source (
        output valid, filtered_x, filtered_y, filtered_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, filtered_x, filtered_y, filtered_z, saturated,
        output ready
    );
endinterface

[sv/three_axis_biquad_lowpass_unit.sv]
// Channel    Dir  Handshake      Payload
// i_req      in   valid/ready    operation, sample_x, sample_y, sample_z
// o_rsp      out  valid/ready    filtered_x, filtered_y, filtered_z, saturated
// i_cfg_*    in   write enable   register index, coefficient data
//
// One request per cycle while no result is held back by the receiver; each result passes
// through products, partial sum, then round/clip into the output register.
// The rate is set by the a1 feedback multiply, which reads the previous output
// and therefore sits in the last stage together with the round and clip.
// Reset is synchronous: it clears all delay lines, coefficients and valid bits.
// A result that is not taken holds the output register and freezes the pipeline;
// i_req.ready drops in the same cycle.
module three_axis_biquad_lowpass_unit #(
    parameter int LANES          = 3,
    parameter int SAMPLE_BITS    = 32,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    tabq_req_if.sink                              i_req,
    tabq_rsp_if.source                            o_rsp,
    input  logic                                  i_cfg_we,
    input  logic [tabq_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [tabq_pkg::COEF_BITS-1:0]        i_cfg_data
);

    // Only the lanes that have fields get hardware.
    localparam int USED_LANES =
        (LANES < tabq_pkg::FIELD_LANES) ? LANES : tabq_pkg::FIELD_LANES;

    tabq_pkg::t_coefs    r_coefs, n_coefs;
    logic                adv;
    logic                take;
    logic                r_s1_vld, r_s2_vld;
    tabq_pkg::t_op       r_s1_op, r_s2_op;
    tabq_pkg::t_op       in_op;
    tabq_pkg::t_lane_ctl lane_ctl;

    tabq_pkg::t_field [tabq_pkg::FIELD_LANES-1:0] samples;
    tabq_pkg::t_field [USED_LANES-1:0]            lane_result;
    logic [USED_LANES-1:0]                        lane_clip;

    // Coefficient registers: write on enable, drop indexes past the list.
    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg_we) begin
            unique case (tabq_pkg::t_reg_idx'(i_cfg_idx))
                tabq_pkg::REG_B0: n_coefs.b0 = i_cfg_data;
                tabq_pkg::REG_B1: n_coefs.b1 = i_cfg_data;
                tabq_pkg::REG_B2: n_coefs.b2 = i_cfg_data;
                tabq_pkg::REG_A1: n_coefs.a1 = i_cfg_data;
                tabq_pkg::REG_A2: n_coefs.a2 = i_cfg_data;
                default:          n_coefs    = r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    // The whole pipeline advances together whenever the output register
    // is empty or its result is being taken.
    assign i_req.ready = adv;
    assign take        = i_req.valid && adv;
    assign in_op       = tabq_pkg::t_op'(i_req.operation);

    // Valid and operation travel alongside the lane datapaths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= i_req.valid;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_op <= in_op;
            r_s2_op <= r_s1_op;
        end
    end

    assign lane_ctl.adv    = adv;
    assign lane_ctl.take   = take;
    assign lane_ctl.in_op  = in_op;
    assign lane_ctl.s2_vld = r_s2_vld;
    assign lane_ctl.s2_op  = r_s2_op;

    assign samples[0] = i_req.sample_x;
    assign samples[1] = i_req.sample_y;
    assign samples[2] = i_req.sample_z;

    // One biquad lane per used axis, all on the shared coefficient set.
    generate
        for (genvar l = 0; l < USED_LANES; l++) begin : g_lane
            tabq_lane #(
                .SAMPLE_BITS    (SAMPLE_BITS),
                .COEF_FRAC_BITS (COEF_FRAC_BITS)
            ) u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (lane_ctl),
                .i_coefs  (r_coefs),
                .i_sample (samples[l]),
                .o_result (lane_result[l]),
                .o_clip   (lane_clip[l])
            );
        end
    endgenerate

    // Collect lane results, OR the clip flags, hold the result register.
    tabq_merge #(
        .USED_LANES (USED_LANES)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s2_vld (r_s2_vld),
        .i_result (lane_result),
        .i_clip   (lane_clip),
        .o_adv    (adv),
        .o_rsp    (o_rsp)
    );

endmodule

[sv/tabq_lane.sv]
module tabq_lane #(
    parameter int SAMPLE_BITS    = 32,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tabq_pkg::t_lane_ctl i_ctl,
    input  tabq_pkg::t_coefs    i_coefs,
    input  tabq_pkg::t_field    i_sample,
    output tabq_pkg::t_field    o_result,
    output logic                o_clip
);

    localparam int FB        = tabq_pkg::FIELD_BITS;
    localparam int PROD_BITS = tabq_pkg::COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS  = PROD_BITS + 3;
    localparam int RND_BITS  = ACC_BITS - COEF_FRAC_BITS;
    localparam int HI_BITS   = RND_BITS - SAMPLE_BITS + 1;

    localparam logic signed [ACC_BITS-1:0] RND_HALF =
        {{(ACC_BITS - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] x_in;

    // input and output delays
    logic signed [SAMPLE_BITS-1:0] r_x1, r_x2, n_x1, n_x2;
    logic signed [SAMPLE_BITS-1:0] r_y1, r_y2, n_y1, n_y2;

    // stage 1: feed-forward products
    logic signed [PROD_BITS-1:0]   r_s1_p0, r_s1_p1, r_s1_p2;
    logic signed [PROD_BITS-1:0]   n_s1_p0, n_s1_p1, n_s1_p2;
    logic signed [SAMPLE_BITS-1:0] r_s1_x;

    // stage 2: partial sum with second feedback term and rounding half
    logic signed [SAMPLE_BITS-1:0] y2_sel;
    logic signed [PROD_BITS-1:0]   fb2_prod;
    logic signed [ACC_BITS-1:0]    r_s2_acc, n_s2_acc;
    logic signed [SAMPLE_BITS-1:0] r_s2_x;

    // stage 3: first feedback term, shift and clip
    logic signed [PROD_BITS-1:0]   fb1_prod;
    logic signed [ACC_BITS-1:0]    acc_sum;
    logic        [RND_BITS-1:0]    acc_rnd;
    logic        [HI_BITS-1:0]     acc_hi;
    logic                          acc_fits;
    logic signed [SAMPLE_BITS-1:0] y_filt;
    logic signed [SAMPLE_BITS-1:0] y_out;

    generate
        if (SAMPLE_BITS <= FB) begin : g_x_narrow
            assign x_in = i_sample[SAMPLE_BITS-1:0];
        end else begin : g_x_wide
            assign x_in = {{(SAMPLE_BITS - FB){1'b0}}, i_sample};
        end
    endgenerate

    // Input history advances as soon as an item is taken.
    always_comb begin
        n_x1 = r_x1;
        n_x2 = r_x2;
        if (i_ctl.take) begin
            unique case (i_ctl.in_op)
                tabq_pkg::OP_FILTER: begin
                    n_x1 = x_in;
                    n_x2 = r_x1;
                end
                tabq_pkg::OP_PRESEED: begin
                    n_x1 = x_in;
                    n_x2 = x_in;
                end
                tabq_pkg::OP_CLEAR: begin
                    n_x1 = '0;
                    n_x2 = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign n_s1_p0 = $signed(i_coefs.b0) * x_in;
    assign n_s1_p1 = $signed(i_coefs.b1) * r_x1;
    assign n_s1_p2 = $signed(i_coefs.b2) * r_x2;

    // Second output delay as seen by the stage-1 item: the item ahead of it
    // may still be in stage 2 and not yet committed.
    always_comb begin
        y2_sel = r_y2;
        if (i_ctl.s2_vld) begin
            unique case (i_ctl.s2_op)
                tabq_pkg::OP_FILTER:  y2_sel = r_y1;
                tabq_pkg::OP_PRESEED: y2_sel = r_s2_x;
                tabq_pkg::OP_CLEAR:   y2_sel = '0;
                default:              y2_sel = r_y2;
            endcase
        end
    end

    assign fb2_prod = $signed(i_coefs.a2) * y2_sel;
    assign n_s2_acc = ACC_BITS'(r_s1_p0) + ACC_BITS'(r_s1_p1) + ACC_BITS'(r_s1_p2)
                    - ACC_BITS'(fb2_prod) + RND_HALF;

    assign fb1_prod = $signed(i_coefs.a1) * r_y1;
    assign acc_sum  = r_s2_acc - ACC_BITS'(fb1_prod);
    assign acc_rnd  = acc_sum[ACC_BITS-1:COEF_FRAC_BITS];
    assign acc_hi   = acc_rnd[RND_BITS-1:SAMPLE_BITS-1];
    assign acc_fits = (acc_hi == '0) || (acc_hi == '1);
    assign y_filt   = acc_fits ? acc_rnd[SAMPLE_BITS-1:0]
                               : (acc_rnd[RND_BITS-1] ? Y_MIN : Y_MAX);

    always_comb begin
        y_out  = '0;
        o_clip = 1'b0;
        n_y1   = r_y1;
        n_y2   = r_y2;
        unique case (i_ctl.s2_op)
            tabq_pkg::OP_FILTER: begin
                y_out  = y_filt;
                o_clip = !acc_fits;
                n_y1   = y_filt;
                n_y2   = r_y1;
            end
            tabq_pkg::OP_PRESEED: begin
                y_out = r_s2_x;
                n_y1  = r_s2_x;
                n_y2  = r_s2_x;
            end
            tabq_pkg::OP_CLEAR: begin
                n_y1 = '0;
                n_y2 = '0;
            end
            default: begin
            end
        endcase
    end

    generate
        if (SAMPLE_BITS >= FB) begin : g_out_trunc
            assign o_result = y_out[FB-1:0];
        end else begin : g_out_sext
            assign o_result = {{(FB - SAMPLE_BITS){y_out[SAMPLE_BITS-1]}}, y_out};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else begin
            r_x1 <= n_x1;
            r_x2 <= n_x2;
            if (i_ctl.adv && i_ctl.s2_vld) begin
                r_y1 <= n_y1;
                r_y2 <= n_y2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s1_p0  <= n_s1_p0;
            r_s1_p1  <= n_s1_p1;
            r_s1_p2  <= n_s1_p2;
            r_s1_x   <= x_in;
            r_s2_acc <= n_s2_acc;
            r_s2_x   <= r_s1_x;
        end
    end

endmodule

[sv/tabq_merge.sv]
module tabq_merge #(
    parameter int USED_LANES = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s2_vld,
    input  tabq_pkg::t_field [USED_LANES-1:0]      i_result,
    input  logic [USED_LANES-1:0]                  i_clip,
    output logic                                   o_adv,
    tabq_rsp_if.source                             o_rsp
);

    logic                                         r_vld;
    tabq_pkg::t_field [tabq_pkg::FIELD_LANES-1:0] r_field, n_field;
    logic                                         r_sat;

    assign o_adv = !r_vld || o_rsp.ready;

    // Lanes without a lane of hardware report zero.
    always_comb begin
        n_field = '0;
        for (int l = 0; l < USED_LANES; l++) begin
            n_field[l] = i_result[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_adv) begin
            r_vld <= i_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_field <= n_field;
            r_sat   <= |i_clip;
        end
    end

    assign o_rsp.valid      = r_vld;
    assign o_rsp.filtered_x = r_field[0];
    assign o_rsp.filtered_y = r_field[1];
    assign o_rsp.filtered_z = r_field[2];
    assign o_rsp.saturated  = r_sat;

endmodule

[sv/tabq_chk.sv]
module tabq_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_req_valid,
    input logic                              i_req_ready,
    input logic                              i_rsp_valid,
    input logic                              i_rsp_ready,
    input logic [tabq_pkg::FIELD_BITS-1:0]   i_rsp_x,
    input logic [tabq_pkg::FIELD_BITS-1:0]   i_rsp_y,
    input logic [tabq_pkg::FIELD_BITS-1:0]   i_rsp_z,
    input logic                              i_rsp_sat
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_x) && $stable(i_rsp_y)
            && $stable(i_rsp_z) && $stable(i_rsp_sat))
        else $error("result changed while stalled");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid |-> i_req_ready)
        else $error("request refused with empty output");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |-> !i_req_ready)
        else $error("request taken while pipeline frozen");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_rsp_valid)
        else $error("result valid right after reset");

endmodule

bind three_axis_biquad_lowpass_unit tabq_chk u_tabq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_x     (o_rsp.filtered_x),
    .i_rsp_y     (o_rsp.filtered_y),
    .i_rsp_z     (o_rsp.filtered_z),
    .i_rsp_sat   (o_rsp.saturated)
);

[tb/sv/tabq_lowpass_checker.sv]
module tabq_lowpass_checker #(
    parameter int COEF_FRAC = 30
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tabq_req_if                               i_req_mon,
    tabq_rsp_if                               i_rsp_mon,
    input  logic                              i_cfg_we,
    input  logic [tabq_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [tabq_pkg::COEF_BITS-1:0]    i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import tabq_pkg::*;

    localparam int ACC_BITS     = 80;
    localparam int REPORT_LIMIT = 10;

    typedef logic signed [ACC_BITS-1:0] t_acc;

    localparam t_acc ROUND_HALF = t_acc'(1) << (COEF_FRAC - 1);
    localparam t_acc SAMPLE_MAX = (t_acc'(1) << (FIELD_BITS - 1)) - 1;
    localparam t_acc SAMPLE_MIN = -(t_acc'(1) << (FIELD_BITS - 1));

    typedef struct packed {
        logic   clip;
        t_field value;
    } t_lane_out;

    typedef struct {
        t_field val [FIELD_LANES];
        logic   sat;
    } t_filtered;

    t_coefs    gains;
    t_field    in_d1  [FIELD_LANES];
    t_field    in_d2  [FIELD_LANES];
    t_field    out_d1 [FIELD_LANES];
    t_field    out_d2 [FIELD_LANES];
    t_filtered filtered_q [$];
    int        fail_cnt;
    int        result_idx;

    function automatic t_acc widen(logic [FIELD_BITS-1:0] v);
        return {{(ACC_BITS - FIELD_BITS){v[FIELD_BITS-1]}}, v};
    endfunction

    // Exact direct form I sum, round half up, clip to the sample range.
    function automatic t_lane_out biquad_lane(t_coefs g, t_field x, t_field x1, t_field x2,
                                              t_field y1, t_field y2);
        t_acc      acc;
        t_lane_out res;
        acc = widen(g.b0) * widen(x) + widen(g.b1) * widen(x1) + widen(g.b2) * widen(x2)
            - widen(g.a1) * widen(y1) - widen(g.a2) * widen(y2);
        acc = (acc + ROUND_HALF) >>> COEF_FRAC;
        res.clip = 1'b0;
        if (acc > SAMPLE_MAX) begin
            acc = SAMPLE_MAX;
            res.clip = 1'b1;
        end else if (acc < SAMPLE_MIN) begin
            acc = SAMPLE_MIN;
            res.clip = 1'b1;
        end
        res.value = acc[FIELD_BITS-1:0];
        return res;
    endfunction

    task automatic predict_request(input logic [OP_BITS-1:0] op, input t_field smp [FIELD_LANES],
                                   output t_filtered res);
        t_lane_out lane;
        res.sat = 1'b0;
        for (int k = 0; k < FIELD_LANES; k++) begin
            res.val[k] = '0;
            case (op)
                OP_FILTER: begin
                    lane = biquad_lane(gains, smp[k], in_d1[k], in_d2[k], out_d1[k], out_d2[k]);
                    in_d2[k]    = in_d1[k];
                    in_d1[k]    = smp[k];
                    out_d2[k]   = out_d1[k];
                    out_d1[k]   = lane.value;
                    res.val[k]  = lane.value;
                    res.sat    |= lane.clip;
                end
                OP_PRESEED: begin
                    in_d1[k]   = smp[k];
                    in_d2[k]   = smp[k];
                    out_d1[k]  = smp[k];
                    out_d2[k]  = smp[k];
                    res.val[k] = smp[k];
                end
                OP_CLEAR: begin
                    in_d1[k]  = '0;
                    in_d2[k]  = '0;
                    out_d1[k] = '0;
                    out_d2[k] = '0;
                end
                default: ;
            endcase
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_filtered want;
        t_field    smp [FIELD_LANES];
        if (!i_rst_n) begin
            gains = '0;
            for (int k = 0; k < FIELD_LANES; k++) begin
                in_d1[k]  = '0;
                in_d2[k]  = '0;
                out_d1[k] = '0;
                out_d2[k] = '0;
            end
            filtered_q.delete();
            fail_cnt   = 0;
            result_idx = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_B0: gains.b0 = i_cfg_data;
                    REG_B1: gains.b1 = i_cfg_data;
                    REG_B2: gains.b2 = i_cfg_data;
                    REG_A1: gains.a1 = i_cfg_data;
                    REG_A2: gains.a2 = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                smp[0] = i_req_mon.sample_x;
                smp[1] = i_req_mon.sample_y;
                smp[2] = i_req_mon.sample_z;
                predict_request(i_req_mon.operation, smp, want);
                filtered_q.push_back(want);
            end
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (filtered_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_LIMIT)
                        $display("MISMATCH result %0d: none expected, got x=%0d y=%0d z=%0d sat=%0b",
                                 result_idx, i_rsp_mon.filtered_x, i_rsp_mon.filtered_y,
                                 i_rsp_mon.filtered_z, i_rsp_mon.saturated);
                end else begin
                    want = filtered_q.pop_front();
                    if (i_rsp_mon.filtered_x !== want.val[0] || i_rsp_mon.filtered_y !== want.val[1]
                        || i_rsp_mon.filtered_z !== want.val[2]
                        || i_rsp_mon.saturated !== want.sat) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_LIMIT) begin
                            $write("MISMATCH result %0d: expected x=%0d y=%0d z=%0d sat=%0b,",
                                   result_idx, want.val[0], want.val[1], want.val[2], want.sat);
                            $display(" got x=%0d y=%0d z=%0d sat=%0b",
                                     i_rsp_mon.filtered_x, i_rsp_mon.filtered_y,
                                     i_rsp_mon.filtered_z, i_rsp_mon.saturated);
                        end
                    end
                end
                result_idx++;
            end
        end
        o_pending    <= filtered_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

[tb/sv/tb.sv]
// Testbench top for the three-axis biquad low-pass unit.
// This module only makes stimulus and gives the verdict; the checker beside
// the block predicts every result and counts mismatches.
module tb;
    import tabq_pkg::*;

    localparam int HALF_PERIOD      = 2;
    localparam int RESET_CYCLES     = 4;
    // Margin waited once every result is back.
    localparam int PIPE_SLACK       = 6;
    localparam int QUIET_LIMIT      = 3000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES    = 10;
    localparam int PHASE_REQUESTS   = 123;

    // The fourth operation code has no name in the package; the block ignores it.
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    localparam t_coef  Q30_ONE    = 32'sh4000_0000;
    localparam t_coef  Q30_HALF   = 32'sh2000_0000;
    localparam t_coef  COEF_MAX   = 32'sh7FFF_FFFF;
    localparam t_coef  COEF_MIN   = 32'sh8000_0000;
    localparam t_field SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam t_field SAMPLE_MIN = 32'sh8000_0000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum int {GAINS_BUTTER, GAINS_WIDE, GAINS_MILD, GAINS_TOP, GAINS_BOTTOM} t_gain_kind;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [COEF_BITS-1:0]    cfg_data;

    int req_gap_pct;        // chance in a hundred of a sender idle cycle
    int rsp_stall_pct;      // chance in a hundred of a receiver stall cycle
    int hold_token;         // bump to start one long receiver hold-off
    int filtered_pending;   // requests whose results have not come back yet
    int mismatch_total;

    tabq_req_if req_ch ();
    tabq_rsp_if rsp_ch ();

    three_axis_biquad_lowpass_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tabq_lowpass_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_ch),
        .i_rsp_mon    (rsp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (mismatch_total),
        .o_pending    (filtered_pending)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Receiver: stall at random, or hold off for a long stretch when asked.
    initial begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL three_axis_biquad_lowpass_unit");
        $finish;
    end

    // Offer one request, with a random gap first, and return at the edge
    // where it is taken. Valid stays high when the next request follows at once.
    task automatic send_request(logic [OP_BITS-1:0] op, t_field x, t_field y, t_field z);
        while ($urandom_range(99) < req_gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.sample_x  <= x;
        req_ch.sample_y  <= y;
        req_ch.sample_z  <= z;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every result is back and the pipeline is quiet.
    task automatic wait_results_done();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (filtered_pending != 0) @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, t_coef value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
    endtask

    // Write all five gains back to back; call only while the block is idle.
    task automatic load_gains(t_coef b0, t_coef b1, t_coef b2, t_coef a1, t_coef a2);
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
        cfg_we <= 1'b0;
    endtask

    task automatic pick_gains(t_gain_kind kind);
        t_coef a2;
        case (kind)
            // Butterworth low-pass at a tenth of the sample rate.
            GAINS_BUTTER: load_gains(32'sd72429577, 32'sd144859154, 32'sd72429577,
                                     -32'sd1227265967, 32'sd443242347);
            GAINS_WIDE:   load_gains($urandom, $urandom, $urandom, $urandom, $urandom);
            // Small feed-forward gains and a stable feedback pair.
            GAINS_MILD: begin
                a2 = t_coef'($urandom_range(0, 32'h2000_0000));
                load_gains(t_coef'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000,
                           t_coef'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000,
                           t_coef'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000,
                           -t_coef'($urandom_range(0, 32'h4000_0000)), a2);
            end
            GAINS_TOP:    load_gains(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
            default:      load_gains(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        endcase
    endtask

    task automatic set_idle(t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                req_gap_pct   = 0;
                rsp_stall_pct <= 0;
            end
            IDLE_SENDER: begin
                req_gap_pct   = 55;
                rsp_stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                req_gap_pct   = 0;
                rsp_stall_pct <= 55;
            end
            default: begin
                req_gap_pct   = 32;
                rsp_stall_pct <= 32;
            end
        endcase
    endtask

    // Small samples and full-range noise about equally often, plus some extremes.
    function automatic t_field rand_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            case ($urandom_range(4))
                0:       return SAMPLE_MAX;
                1:       return SAMPLE_MIN;
                2:       return 32'sd0;
                3:       return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        if (pick < 55)
            return t_field'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        return t_field'($urandom);
    endfunction

    initial begin : stimulus
        int   sent;
        int   pick;
        int   run;
        logic held;
        logic paused;

        // Drive every input to a known value before the first edge.
        cfg_we           <= 1'b0;
        cfg_idx          <= REG_B0;
        cfg_data         <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_FILTER;
        req_ch.sample_x  <= '0;
        req_ch.sample_y  <= '0;
        req_ch.sample_z  <= '0;
        hold_token       <= 0;
        held   = 1'b0;
        paused = 1'b0;
        set_idle(IDLE_NONE);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: gains still at reset, so every filter output is zero.
        send_request(OP_FILTER, SAMPLE_MAX, SAMPLE_MIN, 32'sd1);
        send_request(OP_UNUSED, SAMPLE_MAX, SAMPLE_MIN, -32'sd1);

        // Half gain: ties round toward plus infinity.
        wait_results_done();
        load_gains(Q30_HALF, '0, '0, '0, '0);
        send_request(OP_FILTER, 32'sd1, -32'sd1, 32'sd3);
        send_request(OP_FILTER, SAMPLE_MAX, SAMPLE_MIN, -32'sd3);

        // Integrator: the output runs into the clip after a preseed.
        wait_results_done();
        load_gains(Q30_ONE, '0, '0, -Q30_ONE, '0);
        send_request(OP_PRESEED, SAMPLE_MAX, SAMPLE_MIN, 32'sd0);
        send_request(OP_FILTER, SAMPLE_MAX, SAMPLE_MIN, 32'sd0);
        send_request(OP_FILTER, 32'sd1, 32'sd1, 32'sd1);
        send_request(OP_CLEAR, SAMPLE_MAX, SAMPLE_MIN, 32'sd7);
        send_request(OP_FILTER, 32'sd5, -32'sd5, 32'sd0);

        // Extreme gains, mixed signs.
        wait_results_done();
        load_gains(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        send_request(OP_PRESEED, SAMPLE_MIN, SAMPLE_MAX, -32'sd1);
        send_request(OP_FILTER, SAMPLE_MIN, SAMPLE_MAX, 32'sd1);
        send_request(OP_FILTER, 32'sd0, 32'sd0, 32'sd0);
        send_request(OP_UNUSED, 32'sd0, SAMPLE_MAX, SAMPLE_MIN);
        send_request(OP_FILTER, -32'sd1, 32'sd1, SAMPLE_MAX);

        // Most negative gains everywhere.
        wait_results_done();
        pick_gains(GAINS_BOTTOM);
        send_request(OP_FILTER, SAMPLE_MAX, SAMPLE_MIN, -32'sd1);
        send_request(OP_PRESEED, 32'sd1, -32'sd1, SAMPLE_MIN);
        send_request(OP_FILTER, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX);

        // Random phases: each cycles through a gain set and an idle pattern.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_results_done();
            pick_gains(t_gain_kind'(p % 5));
            set_idle(t_idle_mode'(p % 4));
            sent = 0;
            while (sent < PHASE_REQUESTS) begin
                // Open a burst: seed the delays, wipe them, send the unused code, or keep history.
                pick = $urandom_range(99);
                if (pick < 40)
                    send_request(OP_PRESEED, rand_sample(), rand_sample(), rand_sample());
                else if (pick < 55)
                    send_request(OP_CLEAR, $urandom, $urandom, $urandom);
                else if (pick < 62)
                    send_request(OP_UNUSED, $urandom, $urandom, $urandom);
                if (pick < 62)
                    sent++;
                run = $urandom_range(4, 30);
                repeat (run) begin
                    send_request(OP_FILTER, rand_sample(), rand_sample(), rand_sample());
                    sent++;
                end
                // Hold the receiver off while requests keep coming, so the block backs up.
                if (p == 5 && !held) begin
                    hold_token <= hold_token + 1;
                    held = 1'b1;
                end
                // Pause the sender mid-phase until the pipeline has drained.
                if (p == 6 && !paused && sent > PHASE_REQUESTS / 2) begin
                    wait_results_done();
                    paused = 1'b1;
                end
            end
        end

        wait_results_done();
        if (mismatch_total == 0 && filtered_pending == 0)
            $display("PASS three_axis_biquad_lowpass_unit");
        else
            $display("FAIL three_axis_biquad_lowpass_unit");
        $finish;
    end

endmodule

[filelist.f]
sv/tabq_pkg.sv
sv/tabq_req_if.sv
sv/tabq_rsp_if.sv
sv/tabq_lane.sv
sv/tabq_merge.sv
sv/three_axis_biquad_lowpass_unit.sv
sv/tabq_chk.sv
tb/sv/tabq_lowpass_checker.sv
tb/sv/tb.sv
